[src/assert_macros.svh]
// Assertion macros used by the RTL of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fpfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Shared sizes, register indexes and operation codes of the allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W     = 16;
    localparam int ID_W       = 16;
    localparam int SLOT_W     = 4;
    localparam int BCNT_W     = 5;
    localparam int MODE_W     = 2;
    localparam int WORD_W     = SIZE_W + ID_W;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int ADDR_W     = 3;
    localparam int APB_W      = 32;

    typedef logic [MODE_W-1:0] t_fit_mode;

    localparam t_fit_mode FIT_FIRST = 2'd0;
    localparam t_fit_mode FIT_BEST  = 2'd1;
    localparam t_fit_mode FIT_WORST = 2'd2;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

endpackage

[src/fpfa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/fixed_partition_fit_allocator.sv]
`timescale 1ns / 1ps
// A load beat is written in its accepting cycle. A request's result is valid once N table
// entries are scanned, N being block_count capped at 16, or zero under the undefined
// strategy; first fit stops in the cycle after its first fit is seen.
// Loads take one beat per cycle while no request is in progress; a request holds the input
// until its result is loaded, which waits while a full result register waits on the sink.
// Reset clears allocated marks, config registers, sequencer and output valid, not table RAM.
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Loads partitions into a table and answers allocation requests with first,
// best or worst fit, scanning the table one entry a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_partition_fit_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata from bit 0: block_index[3:0], block_id[19:4], size[35:20],
    // request_id[51:36], zero fill[55:52].
    input  logic [fpfa_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: func.
    input  logic                             i_s_tuser,
    // tlast: batch_end.
    input  logic                             i_s_tlast,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata from bit 0: request_id_out[15:0], chosen_index[19:16],
    // chosen_id[35:20], zero fill[39:36].
    output logic [fpfa_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // tuser: granted.
    output logic                             o_m_tuser,
    // tlast: batch_end_out.
    output logic                             o_m_tlast,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fpfa_pkg::ADDR_W-1:0]      paddr,
    input  logic [fpfa_pkg::APB_W-1:0]       pwdata,
    output logic [fpfa_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Configuration registers.
    fpfa_pkg::t_fit_mode               r_fit_mode;
    logic [fpfa_pkg::BCNT_W-1:0]       r_block_count;

    // Sequencer and scan state.
    logic [1:0]                        r_state;
    logic [fpfa_pkg::CNT_W-1:0]        r_issue;
    logic [fpfa_pkg::CNT_W-1:0]        r_limit;
    logic                              r_cmp_vld;
    logic [fpfa_pkg::IDX_W-1:0]        r_cmp_idx;
    logic                              r_found;
    logic [fpfa_pkg::IDX_W-1:0]        r_best_idx;
    logic [fpfa_pkg::SIZE_W-1:0]       r_best_size;
    logic [fpfa_pkg::ID_W-1:0]         r_best_id;
    logic [fpfa_pkg::SIZE_W-1:0]       r_req_size;
    logic [fpfa_pkg::ID_W-1:0]         r_req_id;
    logic                              r_req_last;
    fpfa_pkg::t_fit_mode               r_mode;
    logic [fpfa_pkg::MAX_BLOCKS-1:0]   r_taken;

    // Result register.
    logic                              r_m_valid;
    logic [fpfa_pkg::ID_W-1:0]         r_m_rid;
    logic                              r_m_granted;
    logic [fpfa_pkg::SLOT_W-1:0]       r_m_idx;
    logic [fpfa_pkg::ID_W-1:0]         r_m_id;
    logic                              r_m_last;

    logic                              cfg_wr;
    logic                              s_accept;
    logic                              is_load;
    logic [fpfa_pkg::SLOT_W-1:0]       in_slot;
    logic [fpfa_pkg::ID_W-1:0]         in_id;
    logic [fpfa_pkg::SIZE_W-1:0]       in_size;
    logic [fpfa_pkg::ID_W-1:0]         in_rid;
    logic [fpfa_pkg::IDX_W+fpfa_pkg::SLOT_W-1:0] slot_ext;
    logic                              slot_ok;
    logic [fpfa_pkg::IDX_W-1:0]        load_idx;
    logic [fpfa_pkg::CNT_W+fpfa_pkg::BCNT_W-1:0] count_ext;
    logic [fpfa_pkg::CNT_W-1:0]        start_limit;
    logic                              issue;
    logic [fpfa_pkg::WORD_W-1:0]       rd_word;
    logic [fpfa_pkg::SIZE_W-1:0]       rd_size;
    logic [fpfa_pkg::ID_W-1:0]         rd_id;
    logic                              fits;
    logic                              better;
    logic                              scan_end;
    logic                              out_load;
    logic [fpfa_pkg::IDX_W+fpfa_pkg::SLOT_W-1:0] best_ext;

    // ------------------------------------------------------------------
    // Configuration port: writes complete in the access cycle.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= fpfa_pkg::FIT_FIRST;
            r_block_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                fpfa_pkg::REG_FIT_MODE:    r_fit_mode    <= pwdata[fpfa_pkg::MODE_W-1:0];
                fpfa_pkg::REG_BLOCK_COUNT: r_block_count <= pwdata[fpfa_pkg::BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            fpfa_pkg::REG_FIT_MODE:    prdata = fpfa_pkg::APB_W'(r_fit_mode);
            fpfa_pkg::REG_BLOCK_COUNT: prdata = fpfa_pkg::APB_W'(r_block_count);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode.
    // ------------------------------------------------------------------
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign is_load    = (i_s_tuser == fpfa_pkg::FUNC_LOAD);
    assign in_slot    = i_s_tdata[3:0];
    assign in_id      = i_s_tdata[19:4];
    assign in_size    = i_s_tdata[35:20];
    assign in_rid     = i_s_tdata[51:36];

    // A load to a slot outside the table is dropped.
    assign slot_ext = {{fpfa_pkg::IDX_W{1'b0}}, in_slot};
    assign slot_ok  = (slot_ext < (fpfa_pkg::IDX_W + fpfa_pkg::SLOT_W)'(fpfa_pkg::MAX_BLOCKS));
    assign load_idx = slot_ext[fpfa_pkg::IDX_W-1:0];

    // A block count above the table depth scans the whole table; an undefined
    // strategy scans nothing and so never grants.
    assign count_ext = {{fpfa_pkg::CNT_W{1'b0}}, r_block_count};
    always_comb begin
        if (r_fit_mode != fpfa_pkg::FIT_FIRST && r_fit_mode != fpfa_pkg::FIT_BEST
            && r_fit_mode != fpfa_pkg::FIT_WORST) begin
            start_limit = '0;
        end else if (count_ext > (fpfa_pkg::CNT_W + fpfa_pkg::BCNT_W)'(fpfa_pkg::MAX_BLOCKS)) begin
            start_limit = fpfa_pkg::CNT_W'(fpfa_pkg::MAX_BLOCKS);
        end else begin
            start_limit = count_ext[fpfa_pkg::CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Partition table: size in the low half, identifier in the high half.
    // The read port is driven by the scan pointer; read data is registered.
    // ------------------------------------------------------------------
    fpfa_ram #(
        .WIDTH (fpfa_pkg::WORD_W),
        .DEPTH (fpfa_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (s_accept && is_load && slot_ok),
        .i_wr_addr (load_idx),
        .i_wr_data ({in_id, in_size}),
        .i_rd_addr (r_issue[fpfa_pkg::IDX_W-1:0]),
        .o_rd_data (rd_word)
    );

    assign rd_size = rd_word[fpfa_pkg::SIZE_W-1:0];
    assign rd_id   = rd_word[fpfa_pkg::WORD_W-1:fpfa_pkg::SIZE_W];

    // The shared comparator: one partition is judged per cycle.
    assign issue = (r_state == S_SCAN) && (r_issue < r_limit);
    assign fits  = r_cmp_vld && !r_taken[r_cmp_idx] && (rd_size >= r_req_size);

    always_comb begin
        better = 1'b0;
        if (fits) begin
            if (!r_found) begin
                better = 1'b1;
            end else if (r_mode == fpfa_pkg::FIT_BEST) begin
                better = (rd_size < r_best_size);
            end else if (r_mode == fpfa_pkg::FIT_WORST) begin
                better = (rd_size > r_best_size);
            end
        end
    end

    // First fit finishes as soon as a candidate is held; a read still in
    // flight at that point is ignored.
    assign scan_end = (r_found && r_mode == fpfa_pkg::FIT_FIRST)
                      || (!issue && !r_cmp_vld);

    assign out_load = (r_state == S_DONE) && (!r_m_valid || i_m_tready);
    assign best_ext = {{fpfa_pkg::SLOT_W{1'b0}}, r_best_idx};

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_issue   <= '0;
            r_limit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (s_accept && !is_load) begin
                        r_state <= S_SCAN;
                        r_issue <= '0;
                        r_limit <= start_limit;
                        r_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= issue;
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (better) begin
                        r_found <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_cmp_vld <= 1'b0;
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state   <= S_IDLE;
                    r_cmp_vld <= 1'b0;
                end
            endcase
        end
    end

    // Request fields and the running candidate.
    always_ff @(posedge i_clk) begin
        if (s_accept && !is_load) begin
            r_req_size <= in_size;
            r_req_id   <= in_rid;
            r_req_last <= i_s_tlast;
            r_mode     <= r_fit_mode;
        end
        if (issue) begin
            r_cmp_idx <= r_issue[fpfa_pkg::IDX_W-1:0];
        end
        if (r_state == S_SCAN && better) begin
            r_best_idx  <= r_cmp_idx;
            r_best_size <= rd_size;
            r_best_id   <= rd_id;
        end
    end

    // Allocated marks: a load frees its slot, a grant takes the chosen one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (s_accept && is_load && slot_ok) begin
            r_taken[load_idx] <= 1'b0;
        end else if (out_load && r_found) begin
            r_taken[r_best_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds a finished beat until the sink takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_rid     <= r_req_id;
            r_m_last    <= r_req_last;
            r_m_granted <= r_found;
            r_m_idx     <= r_found ? best_ext[fpfa_pkg::SLOT_W-1:0] : '0;
            r_m_id      <= r_found ? r_best_id : '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_granted;
    assign o_m_tlast  = r_m_last;
    assign o_m_tdata  = {4'b0000, r_m_id, r_m_idx, r_m_rid};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_issue <= r_limit), "scan pointer ran past the limit")
    `ASSERT_CLK(a_pick_fits, i_clk, i_rst_n, (r_state == S_DONE && r_found) |-> (r_best_size >= r_req_size), "chosen partition is smaller than the request")
    `ASSERT_CLK(a_grant_marks, i_clk, i_rst_n, (out_load && r_found) |=> r_taken[$past(r_best_idx)], "granted partition not marked allocated")
    `ASSERT_CLK(a_refusal_zero, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[35:16] == 20'd0), "refused request carries a partition")

endmodule
